[rtl/swc_pkg.sv]
// Shared types, constants and the heatmap table of the waterfall colourizer.
package swc_pkg;

  // Frame geometry and derived widths.
  localparam int BINS       = 512;
  localparam int BIN_W      = $clog2(BINS);
  localparam int CNT_W      = BIN_W + 1;
  localparam int CFG_BIN_W  = 10;
  localparam int CMP_W      = (CNT_W > CFG_BIN_W) ? CNT_W : CFG_BIN_W;
  localparam int PIX_W      = 9;
  localparam int MAG_W      = 16;
  localparam int LVL_W      = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Queue between the front and the back.
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = Q_PTR_W + 1;

  // Arithmetic constants: 20 dB in Q8.8, reset levels, intensity limits.
  localparam logic signed [LVL_W-1:0] LOW_OFFSET    = 17'sd5120;
  localparam logic signed [LVL_W-1:0] LOW_RESET     = -17'sd5120;
  localparam logic signed [MAG_W-1:0] FLOOR_RESET   = -16'sd12800;
  localparam logic [15:0]             BETA_RESET    = 16'd62259;
  localparam logic [16:0]             BETA_ONE      = 17'd65536;
  localparam logic [7:0]              INT_MAX       = 8'd255;
  localparam logic [7:0]              BLUE_KNEE     = 8'd127;
  localparam int                      DIV_STEPS     = 8;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLOUR_MODE = 3'd0,
    CFG_BETA        = 3'd1,
    CFG_PEAK_LOW    = 3'd2,
    CFG_PEAK_HIGH   = 3'd3,
    CFG_ROW_WIDTH   = 3'd4,
    CFG_PEAK_FLOOR  = 3'd5
  } cfg_reg_t;

  // Colour modes.
  typedef enum logic [1:0] {
    MODE_HEAT = 2'd0,
    MODE_GREY = 2'd1,
    MODE_BLUE = 2'd2
  } colour_mode_t;

  // Back-end sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_COLOUR,
    ST_MUL_OLD,
    ST_MUL_NEW,
    ST_SUM
  } back_state_t;

  // Payload of the input and result channels.
  typedef struct packed {
    logic signed [MAG_W-1:0] magnitude;
    logic                    frame_end;
  } swc_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_index;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic             row_end;
  } swc_out_t;

  // Configuration register file.
  typedef struct packed {
    logic [1:0]              colour_mode;
    logic [15:0]             beta;
    logic [CFG_BIN_W-1:0]    peak_low_bin;
    logic [CFG_BIN_W-1:0]    peak_high_bin;
    logic [CFG_BIN_W-1:0]    row_width;
    logic signed [MAG_W-1:0] peak_floor;
  } swc_cfg_t;

  // One classified bin handed from the front to the back.
  typedef struct packed {
    logic signed [MAG_W-1:0] mag;
    logic [BIN_W-1:0]        idx;
    logic                    row_end;
    logic                    emit;
    logic                    last;
    logic signed [MAG_W-1:0] peak;
  } swc_entry_t;

  // Heatmap table: 256 entries of {red, green, blue}.
  typedef logic [255:0][23:0] heat_lut_t;

  function automatic heat_lut_t heat_build();
    heat_lut_t lut;
    int r;
    int g;
    int b;
    for (int i = 0; i < 256; i++) begin
      b = 0;
      g = 0;
      r = 0;
      if (i <= 51) begin
        b = 5 * i;
      end else if (i <= 178) begin
        b = 357 - 2 * i;
      end
      if (i >= 51 && i <= 153) begin
        g = (5 * (i - 51)) / 2;
      end else if (i >= 154 && i <= 229) begin
        g = (765 - 10 * (i - 153)) / 3;
      end
      if (i >= 128) begin
        r = 2 * i - 255;
      end
      lut[i] = {8'(r), 8'(g), 8'(b)};
    end
    return lut;
  endfunction

  localparam heat_lut_t HEAT_LUT = heat_build();

endpackage

[rtl/swc_queue.sv]
// Short first-in first-out queue of classified bins between front and back.
module swc_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  swc_pkg::swc_entry_t push_data,
  input  logic                pop,
  output swc_pkg::swc_entry_t pop_data,
  output logic                full,
  output logic                empty
);
  import swc_pkg::*;

  swc_entry_t           entries_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r;
  logic [Q_PTR_W-1:0]   wr_ptr_nxt;
  logic [Q_PTR_W-1:0]   rd_ptr_r;
  logic [Q_PTR_W-1:0]   rd_ptr_nxt;
  logic [Q_CNT_W-1:0]   count_r;
  logic [Q_CNT_W-1:0]   count_nxt;

  // Status and next pointer values.
  always_comb begin
    full       = (count_r == Q_CNT_W'(Q_DEPTH));
    empty      = (count_r == '0);
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data = entries_r[rd_ptr_r];

endmodule

[rtl/swc_front.sv]
// Front end: accepts bins, swaps them through the frame store and tracks the frame peak.
module swc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  swc_pkg::swc_cfg_t   cfg,
  input  logic                in_valid,
  output logic                in_stall,
  input  swc_pkg::swc_in_t    in_data,
  input  logic                q_full,
  output logic                push,
  output swc_pkg::swc_entry_t push_data
);
  import swc_pkg::*;

  // Frame store: one row of the previous frame.
  logic [MAG_W-1:0]        store_mem [BINS];
  logic [MAG_W-1:0]        rd_data_r;

  logic [CNT_W-1:0]        bin_r;
  logic [CNT_W-1:0]        bin_nxt;
  logic [CNT_W-1:0]        fill_r;
  logic [CNT_W-1:0]        fill_nxt;
  logic signed [MAG_W-1:0] peak_r;
  logic signed [MAG_W-1:0] peak_nxt;
  logic                    pend_r;
  logic                    pend_nxt;

  // Fields of the transaction waiting for its store read.
  logic [BIN_W-1:0]        pend_idx_r;
  logic                    pend_row_end_r;
  logic                    pend_emit_r;
  logic                    pend_last_r;
  logic                    pend_written_r;
  logic signed [MAG_W-1:0] pend_peak_r;

  logic                    accept;
  logic                    in_range;
  logic                    emit;
  logic                    row_end;
  logic                    in_peak;
  logic                    written;
  logic signed [MAG_W-1:0] peak_new;
  logic [BIN_W-1:0]        addr;

  // Classify the bin at the current position.
  always_comb begin
    in_stall = pend_r || q_full;
    accept   = in_valid && !in_stall;
    addr     = bin_r[BIN_W-1:0];
    in_range = (bin_r < CNT_W'(BINS));
    emit     = in_range && (CMP_W'(bin_r) < CMP_W'(cfg.row_width));
    row_end  = (CMP_W'(bin_r) == CMP_W'(cfg.row_width) - CMP_W'(1));
    written  = (bin_r < fill_r);
    in_peak  = in_range
            && (CMP_W'(bin_r) >= CMP_W'(cfg.peak_low_bin))
            && (CMP_W'(bin_r) < CMP_W'(cfg.peak_high_bin))
            && (in_data.magnitude > peak_r);
    peak_new = in_peak ? in_data.magnitude : peak_r;

    bin_nxt  = bin_r;
    fill_nxt = fill_r;
    peak_nxt = peak_r;
    pend_nxt = pend_r;
    if (pend_r) begin
      pend_nxt = 1'b0;
    end
    if (accept) begin
      if (in_range) begin
        bin_nxt = bin_r + 1'b1;
        if (bin_r == fill_r) begin
          fill_nxt = fill_r + 1'b1;
        end
      end
      peak_nxt = peak_new;
      if (in_data.frame_end) begin
        bin_nxt  = '0;
        peak_nxt = cfg.peak_floor;
      end
      pend_nxt = emit || in_data.frame_end;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_r  <= '0;
      fill_r <= '0;
      peak_r <= FLOOR_RESET;
      pend_r <= 1'b0;
    end else begin
      bin_r  <= bin_nxt;
      fill_r <= fill_nxt;
      peak_r <= peak_nxt;
      pend_r <= pend_nxt;
    end
  end

  // Read the previous frame's value and write the new one in the same cycle.
  always_ff @(posedge clk) begin
    rd_data_r <= store_mem[addr];
    if (accept && in_range) begin
      store_mem[addr] <= in_data.magnitude;
    end
  end

  // Payload of the pending transaction.
  always_ff @(posedge clk) begin
    if (accept) begin
      pend_idx_r     <= addr;
      pend_row_end_r <= row_end;
      pend_emit_r    <= emit;
      pend_last_r    <= in_data.frame_end;
      pend_written_r <= written;
      pend_peak_r    <= peak_new;
    end
  end

  // Positions not yet written since reset read as zero.
  always_comb begin
    push              = pend_r;
    push_data.mag     = pend_written_r ? $signed(rd_data_r) : '0;
    push_data.idx     = pend_idx_r;
    push_data.row_end = pend_row_end_r;
    push_data.emit    = pend_emit_r;
    push_data.last    = pend_last_r;
    push_data.peak    = pend_peak_r;
  end

endmodule

[rtl/swc_back.sv]
// Back end: divides out the intensity, colours the pixel and updates the frame levels.
module swc_back (
  input  logic                clk,
  input  logic                rst_n,
  input  swc_pkg::swc_cfg_t   cfg,
  input  logic                q_empty,
  input  swc_pkg::swc_entry_t q_data,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output swc_pkg::swc_out_t   out_data
);
  import swc_pkg::*;

  back_state_t             state_r;
  back_state_t             state_nxt;
  swc_entry_t              entry_r;
  swc_entry_t              entry_nxt;
  logic signed [MAG_W-1:0] smax_r;
  logic signed [MAG_W-1:0] smax_nxt;
  logic signed [LVL_W-1:0] low_r;
  logic signed [LVL_W-1:0] low_nxt;
  logic [18:0]             rem_r;
  logic [18:0]             rem_nxt;
  logic [17:0]             den_r;
  logic [17:0]             den_nxt;
  logic [7:0]              quo_r;
  logic [7:0]              quo_nxt;
  logic [2:0]              step_r;
  logic [2:0]              step_nxt;
  logic [32:0]             prod_r;
  logic [32:0]             prod_nxt;
  logic [32:0]             acc_r;
  logic [32:0]             acc_nxt;
  logic                    out_valid_r;
  logic                    out_valid_nxt;
  swc_out_t                out_data_r;
  swc_out_t                out_data_nxt;

  logic signed [17:0]      diff;
  logic signed [17:0]      den;
  logic [17:0]             adiff;
  logic [17:0]             aden;
  logic [18:0]             rem2;
  logic [16:0]             mul_a;
  logic [15:0]             mul_b;
  logic [33:0]             sum;
  logic [23:0]             heat_rgb;
  logic [7:0]              red;
  logic [7:0]              green;
  logic [7:0]              blue;
  logic                    out_free;

  // Sequencer and datapath.
  always_comb begin
    state_nxt     = state_r;
    entry_nxt     = entry_r;
    smax_nxt      = smax_r;
    low_nxt       = low_r;
    rem_nxt       = rem_r;
    den_nxt       = den_r;
    quo_nxt       = quo_r;
    step_nxt      = step_r;
    prod_nxt      = prod_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    pop           = 1'b0;

    // Numerator over 256 and denominator, both relative to the low level.
    diff  = 18'(entry_r.mag) - 18'(low_r);
    den   = 18'(smax_r) - 18'(low_r);
    adiff = diff[17] ? 18'(-diff) : 18'(diff);
    aden  = den[17] ? 18'(-den) : 18'(den);
    rem2  = {rem_r[17:0], 1'b0};

    // One shared multiplier for both terms of the smoothed maximum.
    mul_a = (state_r == ST_MUL_OLD) ? {1'b0, cfg.beta} : BETA_ONE - 17'(cfg.beta);
    mul_b = (state_r == ST_MUL_OLD) ? {~smax_r[MAG_W-1], smax_r[MAG_W-2:0]}
                                    : {~entry_r.peak[MAG_W-1], entry_r.peak[MAG_W-2:0]};
    sum   = 34'(acc_r) + 34'(prod_r);

    // Colour from the intensity.
    heat_rgb = HEAT_LUT[quo_r];
    red      = '0;
    green    = '0;
    blue     = '0;
    case (quo_r < BLUE_KNEE)
      1'b1:    blue = {quo_r[6:0], 1'b0};
      default: blue = INT_MAX;
    endcase
    case (cfg.colour_mode)
      MODE_HEAT: begin
        red   = heat_rgb[23:16];
        green = heat_rgb[15:8];
        blue  = heat_rgb[7:0];
      end
      MODE_GREY: begin
        red   = quo_r;
        green = quo_r;
        blue  = quo_r;
      end
      MODE_BLUE: begin
        red   = quo_r;
        green = quo_r;
      end
      default: begin
        blue = '0;
      end
    endcase

    // The output register drains when the receiver takes the transaction.
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    out_free = !out_valid_r || !out_stall;

    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          pop       = 1'b1;
          entry_nxt = q_data;
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        rem_nxt  = {1'b0, adiff};
        den_nxt  = aden;
        quo_nxt  = '0;
        step_nxt = '0;
        if (!entry_r.emit) begin
          state_nxt = ST_MUL_OLD;
        end else if (den == '0 || diff == '0 || (diff[17] != den[17])) begin
          state_nxt = ST_COLOUR;
        end else if (adiff >= aden) begin
          quo_nxt   = INT_MAX;
          state_nxt = ST_COLOUR;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        // Restoring division, one quotient bit a cycle.
        if (rem2 >= {1'b0, den_r}) begin
          rem_nxt = rem2 - {1'b0, den_r};
          quo_nxt = {quo_r[6:0], 1'b1};
        end else begin
          rem_nxt = rem2;
          quo_nxt = {quo_r[6:0], 1'b0};
        end
        step_nxt = step_r + 1'b1;
        if (step_r == 3'(DIV_STEPS - 1)) begin
          state_nxt = ST_COLOUR;
        end
      end
      ST_COLOUR: begin
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.pixel_index = PIX_W'(entry_r.idx);
          out_data_nxt.red         = red;
          out_data_nxt.green       = green;
          out_data_nxt.blue        = blue;
          out_data_nxt.row_end     = entry_r.row_end;
          state_nxt                = entry_r.last ? ST_MUL_OLD : ST_IDLE;
        end
      end
      ST_MUL_OLD: begin
        prod_nxt  = mul_a * 33'(mul_b);
        state_nxt = ST_MUL_NEW;
      end
      ST_MUL_NEW: begin
        acc_nxt   = prod_r;
        prod_nxt  = mul_a * 33'(mul_b);
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        smax_nxt  = {~sum[31], sum[30:16]};
        low_nxt   = LVL_W'(entry_r.peak) - LOW_OFFSET;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control and level registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      smax_r      <= '0;
      low_r       <= LOW_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      smax_r      <= smax_nxt;
      low_r       <= low_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    entry_r    <= entry_nxt;
    rem_r      <= rem_nxt;
    den_r      <= den_nxt;
    quo_r      <= quo_nxt;
    step_r     <= step_nxt;
    prod_r     <= prod_nxt;
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[rtl/spectrum_waterfall_colourizer.sv]
// Top level of the waterfall colourizer: configuration registers and the front, queue and back.
//
// Spectrum bins enter on the in_ channel (valid/stall), one transaction per bin in
// Q8.8 dB, frame_end set on the last bin of a frame. Each bin position below
// row_width gives one pixel on the out_ channel, coloured from the value the same
// position held in the previous frame; bins past the store depth give none.
// Configuration registers are written through cfg_we/cfg_index/cfg_data; the user must
// write them only while idle, which the block itself does not enforce. An accepted bin
// passes through the frame store read, the queue, a setup step, the bit-serial intensity
// divider and a colour step into the output register; a zero, negative or clamped
// intensity skips the divider. On a frame_end bin the back end then runs the
// smoothed-maximum multiply and add; it takes a bin from the queue only when done with
// the last. The front stalls after each pixel or frame_end bin until it is pushed and
// takes any other bin every cycle while the queue is not full; a 4-entry queue decouples front and back.
// Synchronous reset clears the control state, restores the register defaults
// and the frame levels; store positions not yet written since reset read as
// zero through a fill count, so no clearing pass is needed. When the receiver
// stalls, the output register holds its pixel, the back end waits, the queue
// fills and in_stall rises.
module spectrum_waterfall_colourizer (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  swc_pkg::swc_in_t                     in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output swc_pkg::swc_out_t                    out_data,
  input  logic                                 cfg_we,
  input  logic [swc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [swc_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import swc_pkg::*;

  swc_cfg_t   cfg_r;
  swc_cfg_t   cfg_nxt;
  logic       push;
  swc_entry_t push_data;
  logic       pop;
  swc_entry_t pop_data;
  logic       q_full;
  logic       q_empty;

  // Configuration register writes.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_COLOUR_MODE: cfg_nxt.colour_mode   = cfg_data[1:0];
        CFG_BETA:        cfg_nxt.beta          = cfg_data;
        CFG_PEAK_LOW:    cfg_nxt.peak_low_bin  = cfg_data[CFG_BIN_W-1:0];
        CFG_PEAK_HIGH:   cfg_nxt.peak_high_bin = cfg_data[CFG_BIN_W-1:0];
        CFG_ROW_WIDTH:   cfg_nxt.row_width     = cfg_data[CFG_BIN_W-1:0];
        CFG_PEAK_FLOOR:  cfg_nxt.peak_floor    = $signed(cfg_data);
        default:         cfg_nxt               = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.colour_mode   <= MODE_HEAT;
      cfg_r.beta          <= BETA_RESET;
      cfg_r.peak_low_bin  <= CFG_BIN_W'(32);
      cfg_r.peak_high_bin <= CFG_BIN_W'(448);
      cfg_r.row_width     <= CFG_BIN_W'(BINS);
      cfg_r.peak_floor    <= FLOOR_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front end: frame store and peak tracking.
  swc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  // Queue between the two halves.
  swc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  // Back end: intensity, colour and level update.
  swc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_data    (pop_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // The front never pushes into a full queue.
  assert property (@(posedge clk) disable iff (!rst_n) push |-> !q_full)
    else $error("queue push while full");

  // The back never pops an empty queue.
  assert property (@(posedge clk) disable iff (!rst_n) pop |-> !q_empty)
    else $error("queue pop while empty");

  // A pixel lies inside the row and flags its end correctly.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (CMP_W'(out_data.pixel_index) < CMP_W'(cfg_r.row_width)))
    else $error("pixel beyond row width");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.row_end ==
      (CMP_W'(out_data.pixel_index) == CMP_W'(cfg_r.row_width) - CMP_W'(1))))
    else $error("row end flag mismatch");

endmodule

[verif/testbench.sv]
// Self-checking testbench for the spectrum waterfall colourizer: directed table plus random frames.
`timescale 1ns / 1ps

module testbench;
  import swc_pkg::*;

  localparam int LIMIT         = 400000;
  localparam int SETTLE_CYCLES = 120;
  localparam int MAX_REPORTS   = 10;
  localparam int PHASES        = 10;
  localparam int PHASE_BINS    = 80;
  localparam int HOLD_CYCLES   = 400;
  localparam int LONG_PHASE    = 6;
  localparam int PRESSURE_PHASE = 4;

  // Idle patterns of the two channels.
  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  // One row of the directed table: a register write, a bin checked against the
  // predictor, or a bin whose pixel is typed in.
  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_BIN,
    ROW_PIX
  } row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    cfg_reg_t    reg_sel;
    logic [15:0] value;
    logic        last;
    logic [8:0]  px_index;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        row_end;
  } plan_row_t;

  localparam int DIR_ROWS = 42;
  localparam plan_row_t DIR_PLAN [DIR_ROWS] = '{
    // First frame after reset: the store reads zero, which maps to full red.
    '{ROW_PIX, CFG_COLOUR_MODE, 16'h8000,     1'b0, 9'd0, 8'd255, 8'd0, 8'd0, 1'b0},
    '{ROW_PIX, CFG_COLOUR_MODE, 16'h7FFF,     1'b0, 9'd1, 8'd255, 8'd0, 8'd0, 1'b0},
    '{ROW_PIX, CFG_COLOUR_MODE, 16'h0000,     1'b1, 9'd2, 8'd255, 8'd0, 8'd0, 1'b0},
    // Greyscale, no smoothing, peak search from bin zero.
    '{ROW_CFG, CFG_PEAK_LOW,    16'd0,        1'b0, 9'd0, 8'd0, 8'd0, 8'd0, 1'b0},
    '{ROW_CFG, CFG_BETA,        16'd0,        1'b0, 9'd0, 8'd0, 8'd0, 8'd0, 1'b0},
    '{ROW_CFG, CFG_COLOUR_MODE, 16'd1,        1'b0, 9'd0, 8'd0, 8'd0, 8'd0, 1'b0},
    '{ROW_BIN, CFG_COLOUR_MODE, 16'd1000,     1'b0, 9'd0, 8'd0, 8'd0, 8'd0, 1'b0},
    '{ROW_BIN, CFG_COLOUR_MODE, 16'h8000,     1'b0, 9'd0, 8'd0, 8'd0, 8'd0, 1'b0},
    '{ROW_BIN, CFG_COLOUR_MODE, 16'd1000,     1'b1, 9'd0, 8'd0, 8'd0, 8'd0, 1'b0},
    // Full smoothing and a peak 20 dB up: the next frame sees a zero span.
    '{ROW_CFG, CFG_BETA,        16'd65535,    1'b0, 9'd0, 8'd0, 8'd0, 8'd0, 1'b0},
    '{ROW_CFG, CFG_COLOUR_MODE, 16'd2,        1'b0, 9'd0, 8'd0, 8'd0, 8'd0, 1'b0},
    '{ROW_BIN, CFG_COLOUR_MODE, 16'd6120,     1'b0, 9'd0, 8'd0, 8'd0, 8'd0, 1'b0},
    '{ROW_BIN, CFG_COLOUR_MODE, 16'd0,        1'b0, 9'd0, 8'd0, 8'd0, 8'd0, 1'b0},
    '{ROW_BIN, CFG_COLOUR_MODE, 16'd0,        1'b1, 9'd0, 8'd0, 8'd0, 8'd0, 1'b0},
    // Zero span gives intensity zero, which the heatmap shows as black.
    '{ROW_CFG, CFG_COLOUR_MODE, 16'd0,        1'b0, 9'd0, 8'd0, 8'd0, 8'd0, 1'b0},
    '{ROW_PIX, CFG_COLOUR_MODE, -16'sd5000,   1'b0, 9'd0, 8'd0, 8'd0, 8'd0, 1'b0},
    '{ROW_PIX, CFG_COLOUR_MODE, 16'd200,      1'b0, 9'd1, 8'd0, 8'd0, 8'd0, 1'b0},
    '{ROW_PIX, CFG_COLOUR_MODE, 16'h7FFF,     1'b1, 9'd2, 8'd0, 8'd0, 8'd0, 1'b0},
    // Unknown colour mode blanks every pixel; the span is now negative.
    '{ROW_CFG, CFG_COLOUR_MODE, 16'd3,        1'b0, 9'd0, 8'd0, 8'd0, 8'd0, 1'b0},
    '{ROW_PIX, CFG_COLOUR_MODE, 16'd300,      1'b0, 9'd0, 8'd0, 8'd0, 8'd0, 1'b0},
    '{ROW_PIX, CFG_COLOUR_MODE, -16'sd300,    1'b0, 9'd1, 8'd0, 8'd0, 8'd0, 1'b0},
    '{ROW_PIX, CFG_COLOUR_MODE, 16'd1,        1'b1, 9'd2, 8'd0, 8'd0, 8'd0, 1'b0},
    // Two-pixel row: the third bin is stored but not shown.
    '{ROW_CFG, CFG_ROW_WIDTH,   16'd2,        1'b0, 9'd0, 8'd0, 8'd0, 8'd0, 1'b0},
    '{ROW_CFG, CFG_COLOUR_MODE, 16'd1,        1'b0, 9'd0, 8'd0, 8'd0, 8'd0, 1'b0},
    '{ROW_CFG, CFG_BETA,        16'd62259,    1'b0, 9'd0, 8'd0, 8'd0, 8'd0, 1'b0},
    '{ROW_BIN, CFG_COLOUR_MODE, 16'h7FFF,     1'b0, 9'd0, 8'd0, 8'd0, 8'd0, 1'b0},
    '{ROW_BIN, CFG_COLOUR_MODE, 16'h8000,     1'b0, 9'd0, 8'd0, 8'd0, 8'd0, 1'b0},
    '{ROW_BIN, CFG_COLOUR_MODE, 16'd5,        1'b1, 9'd0, 8'd0, 8'd0, 8'd0, 1'b0},
    // Empty row and an empty peak range, top floor written between frames.
    '{ROW_CFG, CFG_ROW_WIDTH,   16'd0,        1'b0, 9'd0, 8'd0, 8'd0, 8'd0, 1'b0},
    '{ROW_CFG, CFG_PEAK_FLOOR,  16'h7FFF,     1'b0, 9'd0, 8'd0, 8'd0, 8'd0, 1'b0},
    '{ROW_CFG, CFG_PEAK_LOW,    16'd5,        1'b0, 9'd0, 8'd0, 8'd0, 8'd0, 1'b0},
    '{ROW_CFG, CFG_PEAK_HIGH,   16'd3,        1'b0, 9'd0, 8'd0, 8'd0, 8'd0, 1'b0},
    '{ROW_BIN, CFG_COLOUR_MODE, 16'd100,      1'b0, 9'd0, 8'd0, 8'd0, 8'd0, 1'b0},
    '{ROW_BIN, CFG_COLOUR_MODE, 16'd200,      1'b1, 9'd0, 8'd0, 8'd0, 8'd0, 1'b0},
    // Widest settings with the lowest floor, blue-boosted grey.
    '{ROW_CFG, CFG_ROW_WIDTH,   16'd1023,     1'b0, 9'd0, 8'd0, 8'd0, 8'd0, 1'b0},
    '{ROW_CFG, CFG_PEAK_FLOOR,  16'h8000,     1'b0, 9'd0, 8'd0, 8'd0, 8'd0, 1'b0},
    '{ROW_CFG, CFG_PEAK_LOW,    16'd0,        1'b0, 9'd0, 8'd0, 8'd0, 8'd0, 1'b0},
    '{ROW_CFG, CFG_PEAK_HIGH,   16'd1023,     1'b0, 9'd0, 8'd0, 8'd0, 8'd0, 1'b0},
    '{ROW_CFG, CFG_COLOUR_MODE, 16'd2,        1'b0, 9'd0, 8'd0, 8'd0, 8'd0, 1'b0},
    '{ROW_BIN, CFG_COLOUR_MODE, 16'hFFFF,     1'b0, 9'd0, 8'd0, 8'd0, 8'd0, 1'b0},
    '{ROW_BIN, CFG_COLOUR_MODE, 16'd0,        1'b0, 9'd0, 8'd0, 8'd0, 8'd0, 1'b0},
    '{ROW_BIN, CFG_COLOUR_MODE, 16'h8000,     1'b1, 9'd0, 8'd0, 8'd0, 8'd0, 1'b0}
  };

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  swc_in_t                in_data;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  swc_out_t               out_data;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // Test state shared by the processes.
  idle_mode_t idle_mode = IDLE_BOTH;
  int         hold_req = 0;
  int         hold_left = 0;
  int         cycle_count = 0;
  int         fail_count = 0;
  int         pixels_checked = 0;
  int         bins_sent = 0;
  int         frames_closed = 0;
  int         held_cycles = 0;
  swc_out_t   pending_pixels [$];

  // Predictor state: last frame's bins, frame levels and register copies.
  logic [15:0]        prev_frame [BINS];
  int unsigned        bin_pos;
  logic signed [15:0] frame_peak;
  logic signed [15:0] smooth_max;
  logic signed [16:0] low_level;
  logic [1:0]         mode_reg;
  logic [15:0]        beta_reg;
  logic [9:0]         peak_lo_reg;
  logic [9:0]         peak_hi_reg;
  logic [9:0]         row_width_reg;
  logic signed [15:0] floor_reg;

  spectrum_waterfall_colourizer DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Clock with a 10 ns period.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Scaled intensity of a stored bin against the current levels.
  function automatic logic [7:0] bin_intensity(input logic signed [15:0] mag);
    longint num;
    longint den;
    longint q;
    num = 256 * (longint'(mag) - longint'(low_level));
    den = longint'(smooth_max) - longint'(low_level);
    if (den == 0 || num == 0) begin
      return 8'd0;
    end
    if ((num < 0) != (den < 0)) begin
      return 8'd0;
    end
    if (num < 0) begin
      num = -num;
      den = -den;
    end
    q = num / den;
    return (q > 255) ? 8'd255 : 8'(q);
  endfunction

  // Heatmap colour: blue fades into green, then red takes over.
  function automatic logic [23:0] heat_rgb(input logic [7:0] lvl);
    int i;
    int r;
    int g;
    int b;
    i = lvl;
    r = 0;
    g = 0;
    b = 0;
    if (i <= 51) begin
      b = 5 * i;
    end else if (i <= 178) begin
      b = 357 - 2 * i;
    end
    if (i >= 51 && i <= 153) begin
      g = (5 * (i - 51)) / 2;
    end else if (i >= 154 && i <= 229) begin
      g = (765 - 10 * (i - 153)) / 3;
    end
    if (i >= 128) begin
      r = 2 * i - 255;
    end
    return {8'(r), 8'(g), 8'(b)};
  endfunction

  // Advance the predictor by one bin and produce the pixel it causes, if any.
  task automatic paint_bin(input swc_in_t b, output bit has_px, output swc_out_t px);
    logic [7:0]  lvl;
    logic [23:0] rgb;
    longint      sum;
    has_px = 1'b0;
    px = '0;
    if (bin_pos < BINS) begin
      if (bin_pos < row_width_reg) begin
        lvl = bin_intensity(signed'(prev_frame[bin_pos]));
        case (mode_reg)
          MODE_HEAT: rgb = heat_rgb(lvl);
          MODE_GREY: rgb = {lvl, lvl, lvl};
          MODE_BLUE: rgb = {lvl, lvl, (lvl < BLUE_KNEE) ? {lvl[6:0], 1'b0} : 8'd255};
          default:   rgb = '0;
        endcase
        px.pixel_index = 9'(bin_pos);
        px.red         = rgb[23:16];
        px.green       = rgb[15:8];
        px.blue        = rgb[7:0];
        px.row_end     = (bin_pos == row_width_reg - 1);
        has_px = 1'b1;
      end
      prev_frame[bin_pos] = b.magnitude;
      if (bin_pos >= peak_lo_reg && bin_pos < peak_hi_reg && b.magnitude > frame_peak) begin
        frame_peak = b.magnitude;
      end
      bin_pos++;
    end
    // Frame close: smooth the maximum, move the low level under the new peak.
    if (b.frame_end) begin
      sum = longint'(beta_reg) * (longint'(smooth_max) + 32768)
          + (65536 - longint'(beta_reg)) * (longint'(frame_peak) + 32768);
      smooth_max = 16'((sum >> 16) - 32768);
      low_level  = 17'(longint'(frame_peak) - 5120);
      frame_peak = floor_reg;
      bin_pos    = 0;
      frames_closed++;
    end
  endtask

  // Register write through the configuration port, mirrored in the predictor.
  task automatic cfg_write(input cfg_reg_t sel, input logic [15:0] val);
    cfg_we    = 1'b1;
    cfg_index = sel;
    cfg_data  = val;
    case (sel)
      CFG_COLOUR_MODE: mode_reg      = val[1:0];
      CFG_BETA:        beta_reg      = val;
      CFG_PEAK_LOW:    peak_lo_reg   = val[9:0];
      CFG_PEAK_HIGH:   peak_hi_reg   = val[9:0];
      CFG_ROW_WIDTH:   row_width_reg = val[9:0];
      CFG_PEAK_FLOOR:  floor_reg     = signed'(val);
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Wait until every pixel is back, then let bins without pixels drain too.
  task automatic wait_idle();
    in_valid = 1'b0;
    while (pending_pixels.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic bit sender_gap();
    case (idle_mode)
      IDLE_SENDER: return $urandom_range(0, 99) < 66;
      IDLE_BOTH:   return $urandom_range(0, 99) < 9;
      default:     return 1'b0;
    endcase
  endfunction

  // Offer one bin, hold it until accepted, and record the pixel it should give.
  task automatic send_bin(input swc_in_t b, input bit typed, input swc_out_t typed_px);
    bit       has_px;
    swc_out_t px;
    while (sender_gap()) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = b;
    forever begin
      @(posedge clk);
      if (!in_stall) begin
        break;
      end
      held_cycles++;
    end
    paint_bin(b, has_px, px);
    if (has_px) begin
      pending_pixels.push_back(typed ? typed_px : px);
    end
    bins_sent++;
    @(negedge clk);
  endtask

  // Receiver: random stalls per idle pattern, plus a long hold-off on request.
  always @(negedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else begin
      case (idle_mode)
        IDLE_RECEIVER: out_stall = ($urandom_range(0, 99) < 66);
        IDLE_BOTH:     out_stall = ($urandom_range(0, 99) < 9);
        default:       out_stall = 1'b0;
      endcase
    end
  end

  // Compare every accepted pixel with the oldest expectation.
  always @(posedge clk) begin
    swc_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
          $display("unexpected pixel: idx %0d rgb %0d,%0d,%0d end %0d",
                   out_data.pixel_index, out_data.red, out_data.green,
                   out_data.blue, out_data.row_end);
        end
      end else begin
        want = pending_pixels.pop_front();
        pixels_checked++;
        if (out_data.pixel_index !== want.pixel_index || out_data.red !== want.red ||
            out_data.green !== want.green || out_data.blue !== want.blue ||
            out_data.row_end !== want.row_end) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS) begin
            $display("pixel mismatch: expected idx %0d rgb %0d,%0d,%0d end %0d",
                     want.pixel_index, want.red, want.green, want.blue, want.row_end);
            $display("                got      idx %0d rgb %0d,%0d,%0d end %0d",
                     out_data.pixel_index, out_data.red, out_data.green,
                     out_data.blue, out_data.row_end);
          end
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("timeout after %0d cycles, %0d pixels outstanding",
               LIMIT, pending_pixels.size());
      $display("testbench failed");
      $finish;
    end
  end

  // Stimulus: reset, directed table, then random phases.
  initial begin
    plan_row_t row;
    swc_in_t   bin;
    swc_out_t  typed_px;
    int        frame_len;
    int        sent;
    int        level_base;
    int        mag_v;
    bit        long_frame;

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    typed_px  = '0;

    // Predictor at its reset state.
    foreach (prev_frame[k]) begin
      prev_frame[k] = '0;
    end
    bin_pos       = 0;
    frame_peak    = FLOOR_RESET;
    smooth_max    = '0;
    low_level     = LOW_RESET;
    mode_reg      = MODE_HEAT;
    beta_reg      = BETA_RESET;
    peak_lo_reg   = 10'd32;
    peak_hi_reg   = 10'd448;
    row_width_reg = 10'd512;
    floor_reg     = FLOOR_RESET;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed table.
    for (int r = 0; r < DIR_ROWS; r++) begin
      row = DIR_PLAN[r];
      if (row.kind == ROW_CFG) begin
        wait_idle();
        cfg_write(row.reg_sel, row.value);
      end else begin
        bin.magnitude        = row.value;
        bin.frame_end        = row.last;
        typed_px.pixel_index = row.px_index;
        typed_px.red         = row.red;
        typed_px.green       = row.green;
        typed_px.blue        = row.blue;
        typed_px.row_end     = row.row_end;
        send_bin(bin, row.kind == ROW_PIX, typed_px);
      end
    end

    // Random phases, each with new settings and its own idle pattern.
    for (int phase = 0; phase < PHASES; phase++) begin
      wait_idle();
      if ($urandom_range(0, 1)) begin
        cfg_write(CFG_COLOUR_MODE, 16'($urandom_range(0, 3)));
      end
      if ($urandom_range(0, 1)) begin
        case ($urandom_range(0, 3))
          0:       cfg_write(CFG_BETA, 16'd0);
          1:       cfg_write(CFG_BETA, 16'hFFFF);
          2:       cfg_write(CFG_BETA, BETA_RESET);
          default: cfg_write(CFG_BETA, 16'($urandom));
        endcase
      end
      if ($urandom_range(0, 1)) begin
        cfg_write(CFG_PEAK_LOW, ($urandom_range(0, 3) == 0) ?
                  16'($urandom_range(0, 1023)) : 16'($urandom_range(0, 20)));
      end
      if ($urandom_range(0, 1)) begin
        cfg_write(CFG_PEAK_HIGH, ($urandom_range(0, 3) == 0) ?
                  16'($urandom_range(0, 1023)) : 16'($urandom_range(5, 60)));
      end
      if (phase == LONG_PHASE) begin
        cfg_write(CFG_ROW_WIDTH, 16'd1023);
      end else if (phase == PRESSURE_PHASE) begin
        // Every bin gives a pixel, so the held-off receiver backs up the input.
        cfg_write(CFG_ROW_WIDTH, 16'd512);
      end else if ($urandom_range(0, 1)) begin
        case ($urandom_range(0, 5))
          0:       cfg_write(CFG_ROW_WIDTH, 16'd1);
          1, 2:    cfg_write(CFG_ROW_WIDTH, 16'($urandom_range(1, 40)));
          3:       cfg_write(CFG_ROW_WIDTH, 16'd512);
          4:       cfg_write(CFG_ROW_WIDTH, 16'd1023);
          default: cfg_write(CFG_ROW_WIDTH, 16'($urandom_range(0, 1023)));
        endcase
      end
      if ($urandom_range(0, 1)) begin
        case ($urandom_range(0, 3))
          0:       cfg_write(CFG_PEAK_FLOOR, 16'h8000);
          1:       cfg_write(CFG_PEAK_FLOOR, 16'h7FFF);
          default: cfg_write(CFG_PEAK_FLOOR, 16'($urandom));
        endcase
      end

      idle_mode  = idle_mode_t'(phase % 4);
      level_base = int'($urandom_range(0, 40000)) - 20000;
      if (phase == PRESSURE_PHASE) begin
        hold_req = HOLD_CYCLES;
      end

      // Frames of random length; a phase may stop in the middle of one.
      sent = 0;
      while (sent < PHASE_BINS) begin
        long_frame = (phase == LONG_PHASE && sent == 0);
        if (long_frame) begin
          frame_len = $urandom_range(BINS + 3, BINS + 18);
        end else if ($urandom_range(0, 99) < 80) begin
          frame_len = $urandom_range(1, 40);
        end else begin
          frame_len = $urandom_range(41, 200);
        end
        for (int k = 0; k < frame_len && (sent < PHASE_BINS || long_frame); k++) begin
          if ($urandom_range(0, 3) == 0) begin
            bin.magnitude = 16'($urandom);
          end else begin
            mag_v = level_base + int'($urandom_range(0, 9000)) - 7000;
            if (mag_v > 32767) begin
              mag_v = 32767;
            end else if (mag_v < -32768) begin
              mag_v = -32768;
            end
            bin.magnitude = 16'(mag_v);
          end
          bin.frame_end = (k == frame_len - 1);
          send_bin(bin, 1'b0, typed_px);
          sent++;
        end
      end
    end

    // Drain and report.
    wait_idle();
    $display("covered %0d bins in %0d frames, %0d pixels checked in all colour modes",
             bins_sent, frames_closed, pixels_checked);
    $display("input held off %0d cycles; row width, peak range and levels swept to extremes",
             held_cycles);
    if (fail_count == 0 && pending_pixels.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
